// ===== design/ptp_pkg.sv =====
package ptp_pkg;

    localparam int VALUE_W = 32;
    localparam int PROD_W  = VALUE_W + 6;
    localparam int DIGIT_W = 6;
    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 8;

    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LB    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UB    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_LO    = 8'h6F;
    localparam logic [CHAR_W-1:0] CH_UO    = 8'h4F;
    localparam logic [CHAR_W-1:0] CH_LD    = 8'h64;
    localparam logic [CHAR_W-1:0] CH_UD    = 8'h44;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;

    localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

    localparam logic [RADIX_W-1:0] RADIX_BIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               bad;
        logic               is_sign;
        logic               is_minus;
        logic               is_zero;
        logic               prefix_ok;
        logic [RADIX_W-1:0] prefix_radix;
    } char_info_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] acc;
        phase_t                    phase;
        logic                      neg;
        logic [RADIX_W-1:0]        radix;
        logic                      err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        acc:   '0,
        phase: PH_START,
        neg:   1'b0,
        radix: RADIX_DEC,
        err:   1'b0
    };

endpackage

// ===== design/ptp_char_decode.sv =====
module ptp_char_decode (
    input  logic [ptp_pkg::CHAR_W-1:0] text_char,
    output ptp_pkg::char_info_t        info
);
    import ptp_pkg::*;

    always_comb
    begin
        info = '0;
        if (text_char >= CH_0 && text_char <= CH_9)
        begin
            info.digit = DIGIT_W'(text_char - CH_0);
        end
        else if (text_char >= CH_LA && text_char <= CH_LZ)
        begin
            info.digit = DIGIT_W'(text_char - CH_LA) + LETTER_BASE;
        end
        else if (text_char >= CH_UA && text_char <= CH_UZ)
        begin
            info.digit = DIGIT_W'(text_char - CH_UA) + LETTER_BASE;
        end
        else
        begin
            info.bad = 1'b1;
        end

        info.is_minus = (text_char == CH_MINUS);
        info.is_sign  = (text_char == CH_MINUS) || (text_char == CH_PLUS);
        info.is_zero  = (text_char == CH_0);

        case (text_char)
            CH_LB, CH_UB:
            begin
                info.prefix_ok    = 1'b1;
                info.prefix_radix = RADIX_BIN;
            end
            CH_LO, CH_UO:
            begin
                info.prefix_ok    = 1'b1;
                info.prefix_radix = RADIX_OCT;
            end
            CH_LD, CH_UD:
            begin
                info.prefix_ok    = 1'b1;
                info.prefix_radix = RADIX_DEC;
            end
            CH_LX, CH_UX:
            begin
                info.prefix_ok    = 1'b1;
                info.prefix_radix = RADIX_HEX;
            end
            default:
            begin
                info.prefix_ok    = 1'b0;
                info.prefix_radix = RADIX_DEC;
            end
        endcase
    end

endmodule

// ===== design/ptp_parse_step.sv =====
module ptp_parse_step (
    input  ptp_pkg::parse_state_t               state,
    input  ptp_pkg::char_info_t                 info,
    input  logic                                last,
    output ptp_pkg::parse_state_t               state_next,
    output logic signed [ptp_pkg::VALUE_W-1:0]  value,
    output logic                                status
);
    import ptp_pkg::*;

    logic signed [PROD_W-1:0] acc_ext;
    logic signed [PROD_W-1:0] radix_ext;
    logic signed [PROD_W-1:0] digit_ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] sum;
    logic                     ovf;
    logic                     digit_err;
    parse_state_t             upd;

    assign acc_ext   = PROD_W'(state.acc);
    assign radix_ext = $signed({{(PROD_W-RADIX_W){1'b0}}, state.radix});
    assign digit_ext = $signed({{(PROD_W-DIGIT_W){1'b0}}, info.digit});
    assign prod      = acc_ext * radix_ext;
    assign sum       = state.neg ? (prod - digit_ext) : (prod + digit_ext);
    assign ovf       = (sum[PROD_W-1:VALUE_W-1] != {(PROD_W-VALUE_W+1){sum[VALUE_W-1]}});
    assign digit_err = info.bad || ({1'b0, info.digit} >= {{(DIGIT_W+1-RADIX_W){1'b0}},
                       state.radix});

    always_comb
    begin
        upd = state;
        if (!state.err)
        begin
            if (state.phase == PH_START && info.is_sign)
            begin
                upd.neg   = info.is_minus;
                upd.phase = PH_SIGNED;
                upd.err   = last;
            end
            else if (state.phase == PH_ZERO && !last && info.prefix_ok)
            begin
                upd.radix = info.prefix_radix;
                upd.phase = PH_DIGITS;
            end
            else
            begin
                if ((state.phase == PH_START || state.phase == PH_SIGNED) && info.is_zero)
                begin
                    upd.phase = PH_ZERO;
                end
                else
                begin
                    upd.phase = PH_DIGITS;
                end
                if (digit_err || ovf)
                begin
                    upd.err = 1'b1;
                end
                else
                begin
                    upd.acc = sum[VALUE_W-1:0];
                end
            end
        end
    end

    assign value      = upd.err ? '0 : upd.acc;
    assign status     = upd.err;
    assign state_next = last ? STATE_RESET : upd;

endmodule

// ===== design/prefixed_integer_text_parser_unit.sv =====
// Parses one signed 32-bit integer token, one character per input transaction, with
// tlast on the final character. A token may start with '+' or '-' and then a 0b/0o/0d/0x
// prefix in either case (it counts only if a character follows it); the default base is
// ten. A character passes the input register, the decode and multiply-add step and the
// state register; a new character is taken every cycle unless a result waits on tready.
// One result transaction follows each token, registered as its last character leaves the
// input reg: tdata = value; tuser = 1 on a syntax, digit or overflow error (value 0).
module prefixed_integer_text_parser_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // [7:0] text_char
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ptp_pkg::VALUE_W-1:0] m_axis_tdata,  // [31:0] parsed_value
    output logic                        m_axis_tuser   // [0] parse_status
);
    import ptp_pkg::*;

    logic                      in_valid_reg;
    logic [CHAR_W-1:0]         in_char_reg;
    logic                      in_last_reg;
    logic                      advance;
    parse_state_t              state_reg;
    parse_state_t              state_next;
    char_info_t                info;
    logic signed [VALUE_W-1:0] step_value;
    logic                      step_status;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [VALUE_W-1:0]        out_value_reg;
    logic                      out_status_reg;

    assign advance        = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign out_valid_next = (advance && in_last_reg) || (out_valid_reg && !m_axis_tready);

    ptp_char_decode u_decode (
        .text_char (in_char_reg),
        .info      (info)
    );

    ptp_parse_step u_step (
        .state      (state_reg),
        .info       (info),
        .last       (in_last_reg),
        .state_next (state_next),
        .value      (step_value),
        .status     (step_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg)
        begin
            out_value_reg  <= step_value;
            out_status_reg <= step_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_status_reg;

    a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("error result carries nonzero value");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> out_valid_reg)
        else $error("token end produced no result");

    a_state_reset_after_token: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (state_reg == STATE_RESET))
        else $error("parser state not cleared after token");

    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_last_reg && state_reg.err) |=> state_reg.err)
        else $error("error flag dropped inside token");

    a_acc_zero_before_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_START || state_reg.phase == PH_SIGNED) |-> (state_reg.acc == '0))
        else $error("accumulator nonzero before first digit");

endmodule
